@@ design/ddsv_pkg.sv @@
// package: shared types, constants and the triangle wave function for the dds voice
`default_nettype none

package ddsv_pkg;

    localparam int DDSV_TABLE_BITS = 8;

    localparam logic [4:0] LEVEL_MAX = 5'd31;
    localparam logic [7:0] DUTY_MID  = 8'd128;
    localparam int         MIX_SHIFT = 5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_END     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_END      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_START  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_STEP   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_VOLUME = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_VOLUME    = 3'd7;

    typedef struct packed {
        logic [15:0] attack_end;
        logic [7:0]  attack_step;
        logic [15:0] decay_end;
        logic [7:0]  decay_step;
        logic [15:0] release_start;
        logic [7:0]  release_step;
        logic [4:0]  sustain_volume;
        logic [4:0]  peak_volume;
    } ddsv_cfg_t;

    localparam ddsv_cfg_t CFG_RESET = '{
        attack_end:     16'd1000,
        attack_step:    8'd8,
        decay_end:      16'd3000,
        decay_step:     8'd60,
        release_start:  16'd12000,
        release_step:   8'd60,
        sustain_volume: 5'd20,
        peak_volume:    5'd31
    };

    typedef struct packed {
        logic [4:0]  level;
        logic [15:0] note_time;
    } ddsv_env_t;

    // triangle sample for an 8-bit index, signed -128..127
    function automatic logic signed [8:0] tri_value(input logic [7:0] j);
        logic [8:0] twice;
        begin
            twice = {j, 1'b0};
            if (j < 8'd64)
                tri_value = $signed(twice);
            else if (j <= 8'd191)
                tri_value = $signed(9'd255 - twice);
            else
                tri_value = $signed(twice);
        end
    endfunction

endpackage

`default_nettype wire

@@ design/ddsv_ifs.sv @@
// interfaces: sample tick input channel and pwm duty output channel
`default_nettype none

interface ddsv_tick_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] new_tuning;

    modport source (output valid, output op, output new_tuning, input ready);
    modport sink (input valid, input op, input new_tuning, output ready);
endinterface

interface ddsv_duty_if;
    logic       valid;
    logic       ready;
    logic [7:0] pwm_duty;

    modport source (output valid, output pwm_duty, input ready);
    modport sink (input valid, input pwm_duty, output ready);
endinterface

`default_nettype wire

@@ design/ddsv_env.sv @@
// envelope: next level and note clock from the attack, decay and release rules
`default_nettype none

module ddsv_env
    import ddsv_pkg::*;
(
    input  var ddsv_cfg_t cfg,
    input  var ddsv_env_t cur,
    input  wire           note_on,
    output ddsv_env_t     nxt
);

    logic [15:0] nt;
    logic [15:0] t;
    logic [15:0] thr_attack;
    logic [15:0] lhs_decay;
    logic [15:0] rhs_decay;
    logic [15:0] lhs_release;
    logic [15:0] rhs_release;
    logic [15:0] gap_decay;
    logic [15:0] gap_release;

    always_comb
    begin
        nt          = note_on ? 16'd1 : cur.note_time;
        t           = nt + 16'd1;
        thr_attack  = 16'(cfg.attack_step) * 16'(cur.level);
        gap_decay   = 16'(cfg.peak_volume) - 16'(cur.level);
        gap_release = 16'(cfg.sustain_volume) - 16'(cur.level);
        rhs_decay   = gap_decay * 16'(cfg.decay_step);
        rhs_release = gap_release * 16'(cfg.release_step);
        lhs_decay   = t - cfg.attack_end;
        lhs_release = t - cfg.release_start;

        nxt = cur;
        if (nt != 16'd0)
        begin
            nxt.note_time = t;
            if (t < cfg.attack_end)
            begin
                if (t > thr_attack && cur.level < LEVEL_MAX)
                    nxt.level = cur.level + 5'd1;
            end
            else if (t < cfg.decay_end)
            begin
                if (lhs_decay > rhs_decay && cur.level > cfg.sustain_volume)
                    nxt.level = cur.level - 5'd1;
            end
            else if (t > cfg.release_start)
            begin
                if (lhs_release > rhs_release)
                begin
                    if (cur.level != 5'd0)
                        nxt.level = cur.level - 5'd1;
                    else
                        nxt.note_time = 16'd0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/dds_triangle_adsr_voice.sv @@
// top level: dds triangle oscillator with adsr volume envelope and pwm duty output
//
// usage
// - tick channel: one transaction per audio sample; op high carries a note-on
//   whose new_tuning becomes the phase increment
// - duty channel: one transaction per tick, the pwm compare value
//   128 plus the mix computed on the previous tick
// - config port: cfg_we with cfg_index and cfg_wdata writes one envelope
//   register; the user must write only while no tick is in flight (not enforced)
// - the duty appears in the output register in the cycle after the tick
//   transaction; one tick per cycle sustained while the duty receiver takes it
// - the whole update (phase add, table, 9x5 product, envelope compares and
//   16-bit products) is combinational from the state registers back into them
// - a stalled receiver keeps the duty in the output register; tick ready
//   drops only while that register is full and not being taken
// - reset clears phase, increment, level, note clock and mix, loads the
//   default envelope settings and empties the output register
`default_nettype none

module dds_triangle_adsr_voice
    import ddsv_pkg::*;
#(
    parameter int TABLE_BITS = DDSV_TABLE_BITS
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    ddsv_tick_if.sink             tick,
    ddsv_duty_if.source           duty,
    input  wire                   cfg_we,
    input  wire [CFG_INDEX_W-1:0] cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IdxShift = 10 - TABLE_BITS;

    ddsv_cfg_t   cfg_reg;
    logic [15:0] phase_reg;
    logic [15:0] increment_reg;
    logic [7:0]  mix_reg;
    ddsv_env_t   env_reg;
    ddsv_env_t   env_next;
    logic        out_valid_reg;
    logic [7:0]  duty_reg;

    logic                  accept;
    logic [15:0]           phase_next;
    logic [TABLE_BITS-1:0] idx;
    logic [9:0]            idx_wide;
    logic signed [8:0]     tri_s;
    logic signed [5:0]     lvl_s;
    logic signed [13:0]    prod;
    logic [7:0]            mix_next;

    assign tick.ready    = !out_valid_reg || duty.ready;
    assign accept        = tick.valid && tick.ready;
    assign duty.valid    = out_valid_reg;
    assign duty.pwm_duty = duty_reg;

    always_comb
    begin
        phase_next = phase_reg + increment_reg;
        idx        = phase_next[15 -: TABLE_BITS];
        idx_wide   = 10'(idx) << IdxShift;
        tri_s      = tri_value(idx_wide[9:2]);
        lvl_s      = $signed({1'b0, env_reg.level});
        prod       = tri_s * lvl_s;
        mix_next   = prod[MIX_SHIFT+7:MIX_SHIFT];
    end

    ddsv_env u_env (
        .cfg     (cfg_reg),
        .cur     (env_reg),
        .note_on (tick.op),
        .nxt     (env_next)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTACK_END:     cfg_reg.attack_end     <= cfg_wdata;
                REG_ATTACK_STEP:    cfg_reg.attack_step    <= cfg_wdata[7:0];
                REG_DECAY_END:      cfg_reg.decay_end      <= cfg_wdata;
                REG_DECAY_STEP:     cfg_reg.decay_step     <= cfg_wdata[7:0];
                REG_RELEASE_START:  cfg_reg.release_start  <= cfg_wdata;
                REG_RELEASE_STEP:   cfg_reg.release_step   <= cfg_wdata[7:0];
                REG_SUSTAIN_VOLUME: cfg_reg.sustain_volume <= cfg_wdata[4:0];
                REG_PEAK_VOLUME:    cfg_reg.peak_volume    <= cfg_wdata[4:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            increment_reg <= '0;
            mix_reg       <= '0;
            env_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            mix_reg   <= mix_next;
            env_reg   <= env_next;
            if (tick.op)
                increment_reg <= tick.new_tuning;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (duty.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            duty_reg <= DUTY_MID + mix_reg;
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> duty.valid)
        else $error("no result after tick transaction");

    a_duty_value: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> duty.pwm_duty == DUTY_MID + $past(mix_reg))
        else $error("duty does not match previous mix");

    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (env_reg.level == $past(env_reg.level))
                || (env_reg.level == $past(env_reg.level) + 5'd1)
                || (env_reg.level == $past(env_reg.level) - 5'd1))
        else $error("level moved by more than one step");

    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (env_reg.note_time == 16'd0 && !(accept && tick.op))
            |=> env_reg.note_time == 16'd0)
        else $error("envelope started without note-on");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg) && $stable(env_reg) && $stable(mix_reg))
        else $error("voice state changed without a tick");

endmodule

`default_nettype wire
